### src/cpr_pkg.sv
// shared types, constants and codes for the chunk placement remapper
package cpr_pkg;
   localparam int MAX_CHUNKS = 1024;
   localparam int SW = $clog2(MAX_CHUNKS);
   localparam int CW = SW + 1;

   localparam logic [1:0] KIND_MOVE   = 2'd0;
   localparam logic [1:0] KIND_WIPE   = 2'd1;
   localparam logic [1:0] KIND_ACCESS = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_UNMAPPED = 2'd1;
   localparam logic [1:0] ST_BEYOND   = 2'd2;
   localparam logic [1:0] ST_STALE    = 2'd3;

   localparam logic [0:0] REG_CHUNK_SIZE = 1'd0;
   localparam logic [0:0] REG_FILE_SIZE  = 1'd1;

   typedef enum logic [4:0] {
      S_IDLE, S_DIV, S_CNT, S_LOOK, S_LOOKW, S_CHK, S_PULL, S_PULLW, S_EMIT1,
      S_SWAP, S_SWAPW, S_ORD, S_ORDW, S_UPD, S_FINAL, S_MUL, S_ACC, S_LEN, S_CLR
   } state_type;

   // divider request and reply
   typedef struct packed {
      logic        go;
      logic [34:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [34:0] quot;
      logic [24:0] rem;
   } div_rsp_type;
endpackage

### src/cpr_divider.sv
// restoring divider, one quotient bit per cycle, shared for all divisions
module cpr_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [24:0]          divisor,
   input  cpr_pkg::div_req_type req,
   output cpr_pkg::div_rsp_type rsp
);
   import cpr_pkg::*;

   logic [34:0] q_ff, q_in;
   logic [25:0] r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [25:0] trial;
   logic [34:0] step_q;
   logic [25:0] step_r;

   always_comb begin
      trial = {r_ff[24:0], q_ff[34]};
      if (trial >= {1'b0, divisor}) begin
         step_r = trial - {1'b0, divisor};
         step_q = {q_ff[33:0], 1'b1};
      end else begin
         step_r = trial;
         step_q = {q_ff[33:0], 1'b0};
      end
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (req.go) begin
         q_in = req.dividend;
         r_in = '0;
         cnt_in = 6'd35;
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in = step_q;
         r_in = step_r;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   // the reply is the final step itself, unaffected by a new request in the same cycle
   assign rsp.done = run_ff && cnt_ff == 6'd1;
   assign rsp.quot = step_q;
   assign rsp.rem  = step_r[24:0];
endmodule

### src/chunk_placement_remapper.sv
// chunk placement remapper top level: sequencer, maps and shared divider
// a request ends in an offset error, an unmapped read error, a mapped access,
//   or the last beat of a store without or with a swap
// two divisions on the shared divider (chunk count, then chunk index) come first
// throughput: one request at a time, busy until the cycle of the last beat; no receiver stall
// reset is synchronous; then a pass over all entries clears the forward map with busy high
module chunk_placement_remapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [33:0] req_offset,
   input  logic [24:0] req_access_bytes,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [9:0]  rsp_from_slot,
   output logic [9:0]  rsp_to_slot,
   output logic [24:0] rsp_byte_count,
   output logic [33:0] rsp_phys_offset,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [34:0] csr_data
);
   import cpr_pkg::*;

   logic [24:0] cs_ff;
   logic [34:0] fs_ff;
   logic [24:0] ecs;
   assign ecs = (cs_ff == '0) ? 25'd1 : cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= 25'd1048576;
         fs_ff <= 35'd1048576;
      end else if (csr_write) begin
         case (csr_index)
            REG_CHUNK_SIZE: cs_ff <= csr_data[24:0];
            REG_FILE_SIZE:  fs_ff <= csr_data;
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   div_req_type dreq;
   div_rsp_type drsp;
   cpr_divider u_div (.clock(clock), .reset(reset), .divisor(ecs), .req(dreq), .rsp(drsp));

   // maps; forward entries carry a mapped bit on top of the slot
   logic [SW:0]   fwd_mem [MAX_CHUNKS];
   logic [SW-1:0] rev_mem [MAX_CHUNKS];
   logic [SW-1:0] f_addr, r_addr, r_wdata, r_rd_ff;
   logic [SW:0]   f_wdata, f_rd_ff;
   logic          f_we, r_we;
   logic [CW-1:0] used_ff, used_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic          fv_rd;
   logic [SW-1:0] fslot_rd;
   assign fv_rd = f_rd_ff[SW];
   assign fslot_rd = f_rd_ff[SW-1:0];

   always_ff @(posedge clock) begin
      if (f_we) fwd_mem[f_addr] <= f_wdata;
      f_rd_ff <= fwd_mem[f_addr];
      if (r_we) rev_mem[r_addr] <= r_wdata;
      r_rd_ff <= rev_mem[r_addr];
   end

   // request context
   logic        act_ff;
   logic [24:0] bytes_ff;
   logic [34:0] cid_ff;
   logic [24:0] rem_ff;
   logic [CW-1:0] n_ff;
   logic [34:0] lastlen_ff;
   logic [SW-1:0] f_ff, empty_ff, oid_ff, slot_ff, old_ff;
   logic        pulled_ff;
   logic [33:0] soff_ff;
   logic        act_in, pulled_in;
   logic [24:0] bytes_in, rem_in;
   logic [34:0] cid_in, lastlen_in;
   logic [CW-1:0] n_in;
   logic [SW-1:0] f_in, empty_in, oid_in, slot_in, old_in;
   logic [33:0] soff_in;
   // length unit operands
   logic [SW-1:0] la_ff, la_in, lb_ff, lb_in;
   logic [24:0]   lmin;

   function automatic logic [24:0] clen(input logic [SW-1:0] c, input logic [CW-1:0] n,
                                        input logic [34:0] ll, input logic [24:0] cs);
      if ({1'b0, c} == n - 1'b1) return ll[24:0];
      return cs;
   endfunction

   logic [24:0] l_a, l_b;
   assign l_a = clen(la_ff, n_ff, lastlen_ff, ecs);
   assign l_b = clen(lb_ff, n_ff, lastlen_ff, ecs);
   assign lmin = (l_a < l_b) ? l_a : l_b;

   // output register
   logic        o_stb_ff, o_stb_in, o_last_ff, o_last_in;
   logic [1:0]  o_kind_ff, o_kind_in, o_st_ff, o_st_in;
   logic [9:0]  o_from_ff, o_from_in, o_to_ff, o_to_in;
   logic [24:0] o_bc_ff, o_bc_in;
   logic [33:0] o_so_ff, o_so_in;

   logic [34:0] cnt_q;
   logic [59:0] prod;
   logic [34:0] lprod;
   assign prod = {50'd0, slot_ff} * {35'd0, ecs};
   assign lprod = {24'd0, n_ff - 1'b1} * {10'd0, ecs};
   assign cnt_q = drsp.quot + {34'd0, drsp.rem != '0};

   always_comb begin
      state_in = state_ff;
      dreq.go = 1'b0;
      dreq.dividend = '0;
      {act_in, bytes_in, cid_in, rem_in, n_in, lastlen_in} =
         {act_ff, bytes_ff, cid_ff, rem_ff, n_ff, lastlen_ff};
      {f_in, empty_in, oid_in, slot_in, old_in, pulled_in, soff_in} =
         {f_ff, empty_ff, oid_ff, slot_ff, old_ff, pulled_ff, soff_ff};
      la_in = la_ff; lb_in = lb_ff;
      used_in = used_ff;
      clr_in = clr_ff;
      f_addr = cid_ff[SW-1:0]; f_we = 1'b0; f_wdata = '0;
      r_addr = cid_ff[SW-1:0]; r_we = 1'b0; r_wdata = '0;
      o_stb_in = 1'b0; o_kind_in = KIND_ERROR; o_from_in = '0; o_to_in = '0;
      o_bc_in = '0; o_so_in = '0; o_st_in = ST_OK; o_last_in = 1'b0;
      case (state_ff)
         S_CLR: begin
            f_addr = clr_ff; f_we = 1'b1; f_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SW'(MAX_CHUNKS - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (start) begin
            act_in = req_action; bytes_in = req_access_bytes;
            dreq.go = 1'b1; dreq.dividend = fs_ff;
            cid_in = {1'b0, req_offset};
            state_in = S_CNT;
         end
         S_CNT: if (drsp.done) begin
            n_in = (cnt_q > 35'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS) : cnt_q[CW-1:0];
            dreq.go = 1'b1; dreq.dividend = cid_ff;
            state_in = S_DIV;
         end
         S_DIV: if (drsp.done) begin
            cid_in = drsp.quot; rem_in = drsp.rem;
            state_in = S_LEN;
         end
         S_LEN: begin
            // length of the last chunk: total bytes - (n-1)*cs, capped
            lastlen_in = fs_ff - lprod;
            if (lastlen_in > {10'd0, ecs}) lastlen_in = {10'd0, ecs};
            if (cid_ff >= {24'd0, n_ff}) begin
               o_stb_in = 1'b1; o_st_in = ST_BEYOND; o_last_in = 1'b1;
               state_in = S_IDLE;
            end else state_in = S_LOOK;
         end
         S_LOOK: begin
            f_addr = cid_ff[SW-1:0];
            state_in = S_LOOKW;
         end
         S_LOOKW: begin
            if (fv_rd) begin
               slot_in = fslot_rd;
               state_in = S_MUL;
            end else if (!act_ff) begin
               o_stb_in = 1'b1; o_st_in = ST_UNMAPPED; o_last_in = 1'b1;
               state_in = S_IDLE;
            end else if (used_ff >= n_ff) begin
               o_stb_in = 1'b1; o_st_in = ST_STALE; o_last_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               f_in = used_ff[SW-1:0];
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            r_addr = f_ff; r_we = 1'b1; r_wdata = f_ff;
            used_in = used_ff + 1'b1;
            f_addr = f_ff;
            state_in = S_PULL;
         end
         S_PULL: begin
            if (fv_rd && fslot_rd < f_ff) begin
               pulled_in = 1'b1; old_in = fslot_rd; empty_in = fslot_rd;
               la_in = fslot_rd; lb_in = f_ff;
            end else begin
               pulled_in = 1'b0; empty_in = f_ff;
               la_in = f_ff; lb_in = f_ff;
            end
            state_in = S_EMIT1;
         end
         S_EMIT1: begin
            o_stb_in = 1'b1;
            o_kind_in = pulled_ff ? KIND_MOVE : KIND_WIPE;
            o_from_in = pulled_ff ? 10'(old_ff) : '0;
            o_to_in = 10'(f_ff);
            o_bc_in = lmin;
            if (pulled_ff) begin
               f_addr = f_ff; f_we = 1'b1; f_wdata = {1'b1, f_ff};
            end
            la_in = cid_ff[SW-1:0]; lb_in = empty_ff;
            state_in = S_SWAP;
         end
         S_SWAP: begin
            if ({24'd0, used_ff} > cid_ff && cid_ff[SW-1:0] != empty_ff) begin
               o_stb_in = 1'b1; o_kind_in = KIND_MOVE;
               o_from_in = 10'(cid_ff[SW-1:0]); o_to_in = 10'(empty_ff);
               o_bc_in = lmin;
               r_addr = cid_ff[SW-1:0];
               state_in = S_SWAPW;
            end else begin
               f_addr = cid_ff[SW-1:0]; f_we = 1'b1; f_wdata = {1'b1, empty_ff};
               r_addr = empty_ff; r_we = 1'b1; r_wdata = cid_ff[SW-1:0];
               slot_in = empty_ff;
               state_in = S_MUL;
            end
         end
         S_SWAPW: begin
            oid_in = r_rd_ff;
            // rev entries hold SW bits; a stale entry is one at or past n
            if ({1'b0, r_rd_ff} >= n_ff) begin
               o_stb_in = 1'b1; o_st_in = ST_STALE; o_last_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               f_addr = cid_ff[SW-1:0]; f_we = 1'b1; f_wdata = {1'b1, cid_ff[SW-1:0]};
               r_addr = cid_ff[SW-1:0]; r_we = 1'b1; r_wdata = cid_ff[SW-1:0];
               state_in = S_ORD;
            end
         end
         S_ORD: begin
            f_addr = oid_ff; f_we = 1'b1; f_wdata = {1'b1, empty_ff};
            r_addr = empty_ff; r_we = 1'b1; r_wdata = oid_ff;
            state_in = S_ORDW;
         end
         S_ORDW: begin
            f_addr = cid_ff[SW-1:0];
            state_in = S_UPD;
         end
         S_UPD: begin
            slot_in = fslot_rd;
            state_in = S_MUL;
         end
         S_MUL: begin
            soff_in = 34'(prod) + {9'd0, rem_ff};
            state_in = S_ACC;
         end
         S_ACC: begin
            o_stb_in = 1'b1; o_kind_in = KIND_ACCESS; o_bc_in = bytes_ff;
            o_so_in = soff_ff; o_last_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         used_ff <= '0;
         o_stb_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         used_ff <= used_in;
         o_stb_ff <= o_stb_in;
      end
      {act_ff, bytes_ff, cid_ff, rem_ff, n_ff, lastlen_ff} <=
         {act_in, bytes_in, cid_in, rem_in, n_in, lastlen_in};
      {f_ff, empty_ff, oid_ff, slot_ff, old_ff, pulled_ff, soff_ff} <=
         {f_in, empty_in, oid_in, slot_in, old_in, pulled_in, soff_in};
      la_ff <= la_in; lb_ff <= lb_in;
      o_kind_ff <= o_kind_in; o_from_ff <= o_from_in; o_to_ff <= o_to_in;
      o_bc_ff <= o_bc_in; o_so_ff <= o_so_in; o_st_ff <= o_st_in; o_last_ff <= o_last_in;
   end

   always_comb begin
      busy = state_ff != S_IDLE;
   end
   assign rsp_strobe = o_stb_ff;
   assign rsp_kind = o_kind_ff;
   assign rsp_from_slot = o_from_ff;
   assign rsp_to_slot = o_to_ff;
   assign rsp_byte_count = o_bc_ff;
   assign rsp_phys_offset = o_so_ff;
   assign rsp_status = o_st_ff;
   assign rsp_last = o_last_ff & o_stb_ff;

   a_used_le_max: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_CHUNKS)) else $error("slot count overflow");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> state_ff == S_IDLE) else $error("last beat while working");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == KIND_ERROR |-> rsp_last) else $error("error not last");
endmodule
